### sv/hpt_pkg.sv
// Package for the hall pulse tachometer: codes, states and constants.
`default_nettype none
package hpt_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam logic [2:0]  CH_MASK  = 3'((1 << CHANNELS) - 1);

  // 60000 * 256 split as a 16-bit multiplier constant and an 8-bit shift
  localparam logic [15:0] MUL_K    = 16'd60000;
  localparam int unsigned MUL_STEPS = 16;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_EDGE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] SM_HALL3 = 2'd0;
  localparam logic [1:0] SM_HALL1 = 2'd1;
  localparam logic [1:0] SM_OPT   = 2'd2;
  localparam logic [1:0] SM_HALL2 = 2'd3;

  localparam logic [1:0] REG_SENSOR_MODE = 2'd0;
  localparam logic [1:0] REG_POLE_COUNT  = 2'd1;
  localparam logic [1:0] REG_MIN_INTVL   = 2'd2;
  localparam logic [1:0] REG_STALL_TMO   = 2'd3;

  localparam logic [1:0]  RST_SENSOR_MODE = 2'd0;
  localparam logic [7:0]  RST_POLE_COUNT  = 8'd4;
  localparam logic [15:0] RST_MIN_INTVL   = 16'd10;
  localparam logic [15:0] RST_STALL_TMO   = 16'd1000;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_SHORT = 2'd1,
    ST_STALL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### sv/hall_pulse_tachometer_core.sv
// Tick, edge and read handling; serial multiply and restoring divide for rpm.
// A tick or edge word is taken in the idle state and gives no result. A short or stalled
// read goes from accept to the done state, a saturated one after the multiply steps and
// the saturation check. Other reads: accept, 16 bit-serial multiply steps, one saturation
// check, 32 restoring divide steps and the done state; a busy output adds stalls.
// Throughput: one word per cycle for ticks and edges; reads hold the input.
// Reset: asynchronous, active low; counters and times zero, registers default.
`default_nettype none
module hall_pulse_tachometer_core
  import hpt_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = CHANNELS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [2:0]  edge_mask_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      rpm_fixed_o,
  output logic [1:0]       status_o,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] CH_EN = 3'((1 << NUM_CHANNELS) - 1);

  state_e state_q, state_d;

  logic [1:0]  sensor_mode_q;
  logic [7:0]  pole_count_q;
  logic [15:0] min_intvl_q;
  logic [15:0] stall_tmo_q;

  logic [31:0] clock_ms_q, clock_ms_d;
  logic [31:0] pulse_total_q, pulse_total_d;
  logic [31:0] last_read_time_q, last_read_time_d;
  logic [31:0] last_read_pulses_q, last_read_pulses_d;
  logic [31:0] last_pulse_time_q, last_pulse_time_d;

  logic [47:0] num_q, num_d;
  logic [47:0] mcand_q, mcand_d;
  logic [41:0] den_q, den_d;
  logic [41:0] elap_q, elap_d;
  logic [9:0]  ppr_q, ppr_d;
  logic [41:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] res_q, res_d;
  status_e     res_st_q, res_st_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rpm_q;
  status_e     out_st_q;

  logic        in_fire, cfg_wr, out_free;
  logic [31:0] elapsed, pulses, since_pulse;
  logic        is_short, is_stall, is_sat;
  logic [7:0]  pole_eff;
  logic [9:0]  ppr;
  logic [2:0]  en_mask, hit;
  logic [1:0]  n_hit;
  logic [42:0] trial, diff;
  logic        q_bit;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_q || out_ready_i;
  assign pready   = 1'b1;

  assign elapsed     = clock_ms_q - last_read_time_q;
  assign pulses      = pulse_total_q - last_read_pulses_q;
  assign since_pulse = clock_ms_q - last_pulse_time_q;
  assign is_short    = (elapsed == 32'd0) || (elapsed < {16'd0, min_intvl_q});
  assign is_stall    = since_pulse > {16'd0, stall_tmo_q};
  assign is_sat      = {18'd0, num_q[47:24]} >= den_q;

  assign pole_eff = (pole_count_q == 8'd0) ? 8'd1 : pole_count_q;

  always_comb begin
    case (sensor_mode_q)
      SM_HALL3: begin
        ppr     = {2'b0, pole_eff} + {1'b0, pole_eff, 1'b0};
        en_mask = 3'b111;
      end
      SM_HALL1: begin
        ppr     = {2'b0, pole_eff};
        en_mask = 3'b001;
      end
      SM_OPT: begin
        ppr     = 10'd1;
        en_mask = 3'b001;
      end
      SM_HALL2: begin
        ppr     = {1'b0, pole_eff, 1'b0};
        en_mask = 3'b011;
      end
      default: begin
        ppr     = 10'd1;
        en_mask = 3'b001;
      end
    endcase
  end

  assign hit   = edge_mask_i & en_mask & CH_EN;
  assign n_hit = {1'b0, hit[0]} + {1'b0, hit[1]} + {1'b0, hit[2]};

  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign q_bit = trial >= {1'b0, den_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (mode_i == MODE_READ)) begin
          if (is_short || is_stall) begin
            state_d = S_DONE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (cnt_q == 5'(MUL_STEPS - 1)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = is_sat ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    clock_ms_d         = clock_ms_q;
    pulse_total_d      = pulse_total_q;
    last_read_time_d   = last_read_time_q;
    last_read_pulses_d = last_read_pulses_q;
    last_pulse_time_d  = last_pulse_time_q;
    num_d    = num_q;
    mcand_d  = mcand_q;
    den_d    = den_q;
    elap_d   = elap_q;
    ppr_d    = ppr_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    res_d    = res_q;
    res_st_d = res_st_q;
    cnt_d    = 5'd0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            MODE_TICK: clock_ms_d = clock_ms_q + 32'd1;
            MODE_EDGE: begin
              if (n_hit != 2'd0) begin
                pulse_total_d     = pulse_total_q + {30'd0, n_hit};
                last_pulse_time_d = clock_ms_q;
              end
            end
            MODE_READ: begin
              res_d   = 32'd0;
              num_d   = 48'd0;
              mcand_d = {16'd0, pulses};
              den_d   = 42'd0;
              elap_d  = {10'd0, elapsed};
              ppr_d   = ppr;
              if (is_short) begin
                res_st_d = ST_SHORT;
              end else begin
                last_read_time_d   = clock_ms_q;
                last_read_pulses_d = pulse_total_q;
                res_st_d = is_stall ? ST_STALL : ST_VALID;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (MUL_K[cnt_q[3:0]]) begin
          num_d = num_q + mcand_q;
        end
        mcand_d = {mcand_q[46:0], 1'b0};
        if (ppr_q[0]) begin
          den_d = den_q + elap_q;
        end
        elap_d = {elap_q[40:0], 1'b0};
        ppr_d  = {1'b0, ppr_q[9:1]};
      end
      S_CHECK: begin
        if (is_sat) begin
          res_d = '1;
        end else begin
          rem_d = {18'd0, num_q[47:24]};
          quo_d = {num_q[23:0], 8'd0};
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        rem_d = q_bit ? diff[41:0] : trial[41:0];
        quo_d = {quo_q[30:0], q_bit};
        res_d = {quo_q[30:0], q_bit};
      end
      default: ;
    endcase
  end

  assign out_valid_d = (state_q == S_DONE && out_free) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      out_valid_q        <= 1'b0;
      cnt_q              <= 5'd0;
      clock_ms_q         <= 32'd0;
      pulse_total_q      <= 32'd0;
      last_read_time_q   <= 32'd0;
      last_read_pulses_q <= 32'd0;
      last_pulse_time_q  <= 32'd0;
      sensor_mode_q      <= RST_SENSOR_MODE;
      pole_count_q       <= RST_POLE_COUNT;
      min_intvl_q        <= RST_MIN_INTVL;
      stall_tmo_q        <= RST_STALL_TMO;
    end else begin
      state_q            <= state_d;
      out_valid_q        <= out_valid_d;
      cnt_q              <= cnt_d;
      clock_ms_q         <= clock_ms_d;
      pulse_total_q      <= pulse_total_d;
      last_read_time_q   <= last_read_time_d;
      last_read_pulses_q <= last_read_pulses_d;
      last_pulse_time_q  <= last_pulse_time_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_SENSOR_MODE: sensor_mode_q <= pwdata[1:0];
          REG_POLE_COUNT:  pole_count_q  <= pwdata[7:0];
          REG_MIN_INTVL:   min_intvl_q   <= pwdata[15:0];
          REG_STALL_TMO:   stall_tmo_q   <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    mcand_q  <= mcand_d;
    den_q    <= den_d;
    elap_q   <= elap_d;
    ppr_q    <= ppr_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    res_q    <= res_d;
    res_st_q <= res_st_d;
    if (state_q == S_DONE && out_free) begin
      out_rpm_q <= res_q;
      out_st_q  <= res_st_q;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SENSOR_MODE: prdata = {30'd0, sensor_mode_q};
      REG_POLE_COUNT:  prdata = {24'd0, pole_count_q};
      REG_MIN_INTVL:   prdata = {16'd0, min_intvl_q};
      REG_STALL_TMO:   prdata = {16'd0, stall_tmo_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign rpm_fixed_o = out_rpm_q;
  assign status_o    = out_st_q;

`ifndef SYNTH
  a_zero_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SHORT || status_o == ST_STALL) |-> rpm_fixed_o == 32'd0)
    else $error("short or stalled read with nonzero rpm");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_valid_q && !out_ready_i |=> state_q == S_DONE)
    else $error("result left done state while output busy");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> den_q != 42'd0)
    else $error("zero divisor after multiply");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("partial remainder not below divisor");
`endif

endmodule
`default_nettype wire
